// ----- hw/rtl/skst_pkg.sv -----
// skst_pkg: shared types and constants for the small key set table
// operation and status codes, result bundle, default sizes
// no dependencies
`timescale 1ns / 1ps

package skst_pkg;

   localparam int MAX_ENTRIES_DEF = 16;
   localparam int KEY_BYTES_DEF   = 8;

   localparam int KEY_W   = 64;
   localparam int KIND_W  = 2;
   localparam int COUNT_W = 5;

   typedef enum logic [KIND_W-1:0] {
      KIND_ADD    = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_QUERY  = 2'd2,
      KIND_CLEAR  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_FULL    = 2'd1,
      STAT_MISSING = 2'd2
   } status_type;

   typedef struct packed {
      logic [COUNT_W-1:0] entry_count;
      logic               present;
      status_type         status;
   } result_type;

endpackage

// ----- hw/rtl/skst_norm.sv -----
// skst_norm: key normalization, clears bytes from the first zero byte on
// and bytes beyond KEY_BYTES, keeps the low KEY_BYTES bytes
// depends on skst_pkg
`timescale 1ns / 1ps

module skst_norm #(
   parameter int KEY_BYTES = skst_pkg::KEY_BYTES_DEF
) (
   input  logic [skst_pkg::KEY_W-1:0] raw_key,
   output logic [8*KEY_BYTES-1:0]     norm_key
);

   always_comb begin
      logic alive;
      alive    = 1'b1;
      norm_key = '0;
      for (int b = 0; b < KEY_BYTES; b++) begin
         alive = alive & (raw_key[8*b +: 8] != 8'd0);
         norm_key[8*b +: 8] = alive ? raw_key[8*b +: 8] : 8'd0;
      end
   end

endmodule

// ----- hw/rtl/skst_ctrl.sv -----
// skst_ctrl: key memory and the sequencer that scans, appends and moves entries
// one transaction at a time, result handed on through a valid/ready pair
// depends on skst_pkg
`timescale 1ns / 1ps

module skst_ctrl #(
   parameter int MAX_ENTRIES = skst_pkg::MAX_ENTRIES_DEF,
   parameter int KEY_BYTES   = skst_pkg::KEY_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  skst_pkg::kind_type     req_kind,
   input  logic [8*KEY_BYTES-1:0] req_key,
   output logic                   res_valid,
   input  logic                   res_ready,
   output skst_pkg::result_type   res
);

   localparam int KW  = 8 * KEY_BYTES;
   localparam int CW  = $clog2(MAX_ENTRIES + 1);
   localparam int IW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int OCW = skst_pkg::COUNT_W;

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_SCAN    = 5'b00010,
      ST_MOVE_RD = 5'b00100,
      ST_MOVE_WR = 5'b01000,
      ST_DONE    = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   skst_pkg::kind_type   kind_ff, kind_in;
   skst_pkg::status_type status_ff, status_in;
   logic                 present_ff, present_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        rd_idx_ff, rd_idx_in;
   logic [CW-1:0]        cmp_idx_ff, cmp_idx_in;
   logic                 cmp_valid_ff, cmp_valid_in;
   logic [KW-1:0]        key_ff, key_in;
   logic [IW-1:0]        pos_ff, pos_in;

   logic [KW-1:0] mem [MAX_ENTRIES];
   logic [KW-1:0] mem_q_ff;
   logic          mem_we, mem_re;
   logic [IW-1:0] mem_wa, mem_ra;
   logic [KW-1:0] mem_wd;

   logic [CW-1:0] count_m1;
   logic          hit, last;

   assign count_m1 = count_ff - CW'(1);
   assign hit      = cmp_valid_ff && (mem_q_ff == key_ff);
   assign last     = cmp_valid_ff && ((cmp_idx_ff + CW'(1)) == count_ff);

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      status_in    = status_ff;
      present_in   = present_ff;
      count_in     = count_ff;
      rd_idx_in    = rd_idx_ff;
      cmp_idx_in   = cmp_idx_ff;
      cmp_valid_in = 1'b0;
      key_in       = key_ff;
      pos_in       = pos_ff;
      mem_we       = 1'b0;
      mem_wa       = count_ff[IW-1:0];
      mem_wd       = key_ff;
      mem_re       = 1'b0;
      mem_ra       = rd_idx_ff[IW-1:0];
      req_ready    = 1'b0;
      res_valid    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               kind_in    = req_kind;
               key_in     = req_key;
               status_in  = skst_pkg::STAT_OK;
               present_in = 1'b0;
               rd_idx_in  = '0;
               state_in   = ST_SCAN;
               unique case (req_kind)
                  skst_pkg::KIND_CLEAR: begin
                     count_in = '0;
                     state_in = ST_DONE;
                  end
                  skst_pkg::KIND_ADD: begin
                     if (count_ff >= CW'(MAX_ENTRIES)) begin
                        status_in = skst_pkg::STAT_FULL;
                        state_in  = ST_DONE;
                     end else if (count_ff == '0) begin
                        mem_we   = 1'b1;
                        mem_wd   = req_key;
                        count_in = CW'(1);
                        state_in = ST_DONE;
                     end
                  end
                  skst_pkg::KIND_REMOVE: begin
                     if (count_ff == '0) begin
                        status_in = skst_pkg::STAT_MISSING;
                        state_in  = ST_DONE;
                     end
                  end
                  default: begin
                     if (count_ff == '0) begin
                        state_in = ST_DONE;
                     end
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (rd_idx_ff < count_ff) begin
               mem_re       = 1'b1;
               rd_idx_in    = rd_idx_ff + CW'(1);
               cmp_valid_in = 1'b1;
               cmp_idx_in   = rd_idx_ff;
            end
            if (hit) begin
               state_in = ST_DONE;
               unique case (kind_ff)
                  skst_pkg::KIND_QUERY: present_in = 1'b1;
                  skst_pkg::KIND_REMOVE: begin
                     if (last) begin
                        count_in = count_m1;
                     end else begin
                        pos_in   = cmp_idx_ff[IW-1:0];
                        state_in = ST_MOVE_RD;
                     end
                  end
                  default: ;
               endcase
            end else if (last) begin
               state_in = ST_DONE;
               unique case (kind_ff)
                  skst_pkg::KIND_ADD: begin
                     mem_we   = 1'b1;
                     count_in = count_ff + CW'(1);
                  end
                  skst_pkg::KIND_REMOVE: status_in = skst_pkg::STAT_MISSING;
                  default: ;
               endcase
            end
         end
         ST_MOVE_RD: begin
            mem_re   = 1'b1;
            mem_ra   = count_m1[IW-1:0];
            state_in = ST_MOVE_WR;
         end
         ST_MOVE_WR: begin
            mem_we   = 1'b1;
            mem_wa   = pos_ff;
            mem_wd   = mem_q_ff;
            count_in = count_m1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign res.status      = status_ff;
   assign res.present     = present_ff;
   assign res.entry_count = OCW'(count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         kind_ff      <= skst_pkg::KIND_ADD;
         status_ff    <= skst_pkg::STAT_OK;
         present_ff   <= 1'b0;
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         cmp_idx_ff   <= '0;
         cmp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         status_ff    <= status_in;
         present_ff   <= present_in;
         count_ff     <= count_in;
         rd_idx_ff    <= rd_idx_in;
         cmp_idx_ff   <= cmp_idx_in;
         cmp_valid_ff <= cmp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      pos_ff <= pos_in;
   end

   // key memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         mem_q_ff <= mem[mem_ra];
      end
   end

endmodule

// ----- hw/rtl/small_key_set_table.sv -----
// small_key_set_table: top level of the bounded key set
// depends on skst_pkg, skst_norm and skst_ctrl
//
// usage
//   req channel: req_tuser carries the operation (add, remove, query, clear),
//   req_tdata the key, first byte in the low bits; the key is cut at its
//   first zero byte and at KEY_BYTES bytes before it is stored or compared
//   rsp channel: one transaction per request with status, present flag and
//   the number of keys held afterwards
//   clear, add to a full or empty set and requests on an empty set go
//   straight to the response; others scan the key memory one entry a
//   cycle, and a remove that moves the last entry into the freed slot
//   passes through a further read state and write state
//   one request at a time: the sequencer takes no new request before it
//   has finished the last; the next request is accepted once the previous
//   response sits in the output register
//   reset clears the count, so the set is empty; memory contents are kept
//   a stalled rsp side holds the response and, after one more request,
//   holds req_tready low
`timescale 1ns / 1ps

module small_key_set_table #(
   parameter int MAX_ENTRIES = skst_pkg::MAX_ENTRIES_DEF,
   parameter int KEY_BYTES   = skst_pkg::KEY_BYTES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [skst_pkg::KEY_W-1:0]       req_tdata,  // key
   input  logic [skst_pkg::KIND_W-1:0]      req_tuser,  // kind
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [$bits(skst_pkg::result_type)-1:0] rsp_tdata  // status, present, entry_count
);

   localparam int KW = 8 * KEY_BYTES;

   logic [KW-1:0]        key_norm;
   logic                 res_valid, res_ready;
   skst_pkg::result_type res;

   logic                 rsp_valid_ff, rsp_valid_in;
   skst_pkg::result_type rsp_data_ff, rsp_data_in;

   skst_norm #(
      .KEY_BYTES (KEY_BYTES)
   ) u_norm (
      .raw_key  (req_tdata),
      .norm_key (key_norm)
   );

   skst_ctrl #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .KEY_BYTES   (KEY_BYTES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_kind  (skst_pkg::kind_type'(req_tuser)),
      .req_key   (key_norm),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   // output register
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_data_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
